>>> rtl/ipv4_mac_rewrite_forwarder_macros.svh
// Assertion macros shared by the forwarder RTL.
// Each macro expands to one labelled concurrent assertion on clk, disabled in reset.
`ifndef IPV4_MAC_REWRITE_FORWARDER_MACROS_SVH
`define IPV4_MAC_REWRITE_FORWARDER_MACROS_SVH

// Antecedent holds: consequent holds in the same cycle.
`define IMRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Antecedent holds: consequent holds in the next cycle.
`define IMRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/imrf_pkg.sv
// Shared constants, codes and control structs for the IPv4 forwarder.
// No dependencies; imported by every module of the block.
package imrf_pkg;

    // Lookup table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Frame byte counter
    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 7'd127;
    localparam logic [COUNT_W-1:0] ETH_HEADER_LEN = 7'd14;
    localparam logic [COUNT_W-1:0] IPV4_MIN_LEN   = 7'd34;

    // Header byte positions
    localparam logic [COUNT_W-1:0] POS_TYPE_HI  = 7'd12;
    localparam logic [COUNT_W-1:0] POS_TYPE_LO  = 7'd13;
    localparam logic [COUNT_W-1:0] POS_IHL      = 7'd14;
    localparam logic [COUNT_W-1:0] POS_DST_HEAD = 7'd30;
    localparam logic [COUNT_W-1:0] POS_DST_TAIL = 7'd33;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    // Request command codes
    localparam logic CMD_FRAME_BYTE  = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_DROP     = 2'd0;
    localparam logic [1:0] VERDICT_PASS     = 2'd1;
    localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_RECV   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_SEARCH = 3'b100
    } imrf_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       take;         // request accepted this cycle
        logic       search_start; // reset the slot index
        logic       search_step;  // advance the slot index
        logic       load;         // load the result register, clear frame state
        logic       use_slot;     // result takes the current slot's fields
        logic [1:0] verdict;
    } imrf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       lookup;       // frame passed the length and type checks
        logic [1:0] early_verdict;
        logic       match;        // current slot hits
        logic       last_slot;
    } imrf_status_t;

endpackage

>>> rtl/imrf_ctrl.sv
// Controller of the forwarder: handshakes, end-of-frame check and slot search sequencing.
// Depends on imrf_pkg and the assertion macros header.
`include "ipv4_mac_rewrite_forwarder_macros.svh"

module imrf_ctrl
    import imrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         command,
    input  logic         last_byte,
    input  logic         result_stall,
    input  imrf_status_t status,
    output logic         req_stall,
    output logic         result_valid,
    output imrf_cmd_t    cmd
);

    imrf_state_t state_reg, state_next;
    logic        out_full_reg, out_full_next;
    logic        req_take;
    logic        frame_end;

    // Requests flow only while receiving and the result slot can take a verdict
    assign req_stall    = (state_reg != ST_RECV) || (out_full_reg && result_stall);
    assign req_take     = req_valid && !req_stall;
    assign frame_end    = req_take && (command == CMD_FRAME_BYTE) && last_byte;
    assign result_valid = out_full_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.take         = req_take;
        cmd.verdict      = VERDICT_PASS;
        case (state_reg)
            ST_RECV:
            begin
                if (frame_end)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.lookup)
                begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end
                else
                begin
                    cmd.load    = 1'b1;
                    cmd.verdict = status.early_verdict;
                    state_next  = ST_RECV;
                end
            end
            ST_SEARCH:
            begin
                if (status.match)
                begin
                    cmd.load     = 1'b1;
                    cmd.use_slot = 1'b1;
                    cmd.verdict  = VERDICT_REDIRECT;
                    state_next   = ST_RECV;
                end
                else if (status.last_slot)
                begin
                    cmd.load    = 1'b1;
                    cmd.verdict = VERDICT_PASS;
                    state_next  = ST_RECV;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    // Result register occupancy
    always_comb
    begin
        out_full_next = out_full_reg;
        if (cmd.load)
        begin
            out_full_next = 1'b1;
        end
        else if (out_full_reg && !result_stall)
        begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RECV;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    // A verdict is never written over one still waiting
    `IMRF_ASSERT_SAME(a_load_into_empty, cmd.load, !out_full_reg || !result_stall)
    // Last byte of a frame always leads to the length check
    `IMRF_ASSERT_NEXT(a_end_to_check, frame_end, state_reg == ST_CHECK)
    // The check state is always left in the next cycle
    `IMRF_ASSERT_NEXT(a_check_one_cycle, state_reg == ST_CHECK, state_reg != ST_CHECK)
    // A search ends on a hit or on the last slot
    `IMRF_ASSERT_SAME(a_search_exit, (state_reg == ST_SEARCH) && (status.match || status.last_slot),
        cmd.load)

endmodule

>>> rtl/imrf_datapath.sv
// Datapath of the forwarder: header capture, lookup table, slot compare and result register.
// Depends on imrf_pkg; driven by imrf_ctrl through imrf_cmd_t.
module imrf_datapath
    import imrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  imrf_cmd_t    cmd,
    input  logic         command,
    input  logic [7:0]   data_byte,
    input  logic [3:0]   entry_index,
    input  logic         entry_valid,
    input  logic [31:0]  key_address,
    input  logic [47:0]  new_source_mac,
    input  logic [47:0]  new_dest_mac,
    input  logic [7:0]   entry_interface,
    output imrf_status_t status,
    output logic [1:0]   verdict,
    output logic [7:0]   out_interface,
    output logic [47:0]  source_mac,
    output logic [47:0]  dest_mac
);

    // Per-frame header state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        ether_type_reg, ether_type_next;
    logic [3:0]         header_words_reg, header_words_next;
    logic [31:0]        dest_address_reg, dest_address_next;

    // Lookup table
    logic [TABLE_DEPTH-1:0] slot_valid_reg;
    logic [31:0]            slot_key_reg       [TABLE_DEPTH];
    logic [47:0]            slot_source_mac_reg[TABLE_DEPTH];
    logic [47:0]            slot_dest_mac_reg  [TABLE_DEPTH];
    logic [7:0]             slot_interface_reg [TABLE_DEPTH];
    logic [IDX_W-1:0]       search_idx_reg, search_idx_next;

    // Result register
    logic [1:0]  verdict_reg;
    logic [7:0]  out_interface_reg;
    logic [47:0] source_mac_reg;
    logic [47:0] dest_mac_reg;

    logic               byte_take;
    logic               table_write;
    logic [IDX_W-1:0]   write_idx;
    logic [COUNT_W-1:0] ihl_len;

    assign byte_take   = cmd.take && (command == CMD_FRAME_BYTE);
    assign table_write = cmd.take && (command == CMD_TABLE_WRITE)
                         && (32'(entry_index) < TABLE_DEPTH);
    assign write_idx   = IDX_W'(entry_index);

    // Header capture by byte position
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        ether_type_next   = ether_type_reg;
        header_words_next = header_words_reg;
        dest_address_next = dest_address_reg;
        if (cmd.load)
        begin
            byte_count_next   = '0;
            ether_type_next   = '0;
            header_words_next = '0;
            dest_address_next = '0;
        end
        else if (byte_take)
        begin
            if ((byte_count_reg == POS_TYPE_HI) || (byte_count_reg == POS_TYPE_LO))
            begin
                ether_type_next = {ether_type_reg[7:0], data_byte};
            end
            else if (byte_count_reg == POS_IHL)
            begin
                header_words_next = data_byte[3:0];
            end
            else if ((byte_count_reg >= POS_DST_HEAD) && (byte_count_reg <= POS_DST_TAIL))
            begin
                dest_address_next = {dest_address_reg[23:0], data_byte};
            end
            if (byte_count_reg < COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
    end

    // Minimum frame length implied by the IHL field, for the length check
    assign ihl_len = COUNT_W'({header_words_reg, 2'b00}) + ETH_HEADER_LEN;

    // Status: length and type checks, one slot compared per cycle, lowest index first
    always_comb
    begin
        status.match         = slot_valid_reg[search_idx_reg]
                               && (slot_key_reg[search_idx_reg] == dest_address_reg);
        status.last_slot     = (search_idx_reg == IDX_W'(TABLE_DEPTH - 1));
        status.lookup        = 1'b0;
        status.early_verdict = VERDICT_PASS;
        if (byte_count_reg < ETH_HEADER_LEN)
        begin
            status.early_verdict = VERDICT_DROP;
        end
        else if (ether_type_reg != ETHERTYPE_IPV4)
        begin
            status.early_verdict = VERDICT_PASS;
        end
        else if ((byte_count_reg < IPV4_MIN_LEN) || (byte_count_reg < ihl_len))
        begin
            status.early_verdict = VERDICT_DROP;
        end
        else
        begin
            status.lookup = 1'b1;
        end
    end

    always_comb
    begin
        search_idx_next = search_idx_reg;
        if (cmd.search_start)
        begin
            search_idx_next = '0;
        end
        else if (cmd.search_step)
        begin
            search_idx_next = search_idx_reg + 1'b1;
        end
    end

    // Control and header registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            dest_address_reg <= '0;
            search_idx_reg   <= '0;
            slot_valid_reg   <= '0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            ether_type_reg   <= ether_type_next;
            header_words_reg <= header_words_next;
            dest_address_reg <= dest_address_next;
            search_idx_reg   <= search_idx_next;
            if (table_write)
            begin
                slot_valid_reg[write_idx] <= entry_valid;
            end
        end
    end

    // Table entry fields
    always_ff @(posedge clk)
    begin
        if (table_write)
        begin
            slot_key_reg[write_idx]        <= key_address;
            slot_source_mac_reg[write_idx] <= new_source_mac;
            slot_dest_mac_reg[write_idx]   <= new_dest_mac;
            slot_interface_reg[write_idx]  <= entry_interface;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            verdict_reg <= cmd.verdict;
            if (cmd.use_slot)
            begin
                out_interface_reg <= slot_interface_reg[search_idx_reg];
                source_mac_reg    <= slot_source_mac_reg[search_idx_reg];
                dest_mac_reg      <= slot_dest_mac_reg[search_idx_reg];
            end
            else
            begin
                out_interface_reg <= '0;
                source_mac_reg    <= '0;
                dest_mac_reg      <= '0;
            end
        end
    end

    assign verdict       = verdict_reg;
    assign out_interface = out_interface_reg;
    assign source_mac    = source_mac_reg;
    assign dest_mac      = dest_mac_reg;

endmodule

>>> rtl/ipv4_mac_rewrite_forwarder.sv
// Verdict path: the last byte of a frame leads to the length and type check, which registers
// the verdict for frames that it settles and otherwise starts the slot search, which registers
// it on a hit or at the last slot. Throughput: one frame byte or table write per cycle while
// receiving, unless a waiting verdict is held by result_stall; requests stall during each
// check and search, which compares one slot per cycle.
// Reset: asynchronous, active low; clears frame state and all slot valid bits at once.
// Top level of the forwarder; instantiates imrf_ctrl and imrf_datapath, uses imrf_pkg.
module ipv4_mac_rewrite_forwarder
    import imrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [3:0]  entry_index,
    input  logic        entry_valid,
    input  logic [31:0] key_address,
    input  logic [47:0] new_source_mac,
    input  logic [47:0] new_dest_mac,
    input  logic [7:0]  entry_interface,
    // Result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  verdict,
    output logic [7:0]  out_interface,
    output logic [47:0] source_mac,
    output logic [47:0] dest_mac
);

    imrf_cmd_t    cmd;
    imrf_status_t status;

    imrf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .command      (command),
        .last_byte    (last_byte),
        .result_stall (result_stall),
        .status       (status),
        .req_stall    (req_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    imrf_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .command         (command),
        .data_byte       (data_byte),
        .entry_index     (entry_index),
        .entry_valid     (entry_valid),
        .key_address     (key_address),
        .new_source_mac  (new_source_mac),
        .new_dest_mac    (new_dest_mac),
        .entry_interface (entry_interface),
        .status          (status),
        .verdict         (verdict),
        .out_interface   (out_interface),
        .source_mac      (source_mac),
        .dest_mac        (dest_mac)
    );

endmodule

>>> tb/sv/ipv4_mac_rewrite_forwarder_tb.sv
// Self-checking testbench for ipv4_mac_rewrite_forwarder: directed header, table,
// mid-frame write and long-frame tests, then random frames and table writes against an
// in-bench verdict predictor. Depends on imrf_pkg and the forwarder RTL only.
`timescale 1ns / 1ps

module ipv4_mac_rewrite_forwarder_tb
    import imrf_pkg::*;
;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PCT       = 29;
    localparam int RANDOM_ITEMS   = 450;
    localparam int IHL_UNIT_BYTES = 4;
    localparam int KEY_POOL_SIZE  = 8;

    typedef struct {
        logic        command;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic [31:0] key_address;
        logic [47:0] new_source_mac;
        logic [47:0] new_dest_mac;
        logic [7:0]  entry_interface;
    } request_t;

    typedef struct {
        logic [1:0]  verdict;
        logic [7:0]  iface;
        logic [47:0] smac;
        logic [47:0] dmac;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] key_address;
    logic [47:0] new_source_mac;
    logic [47:0] new_dest_mac;
    logic [7:0]  entry_interface;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  verdict;
    logic [7:0]  out_interface;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;

    // Predictor state: per-frame header capture and the forwarding table
    logic [6:0]  frame_len;
    logic [15:0] frame_type;
    logic [3:0]  frame_ihl;
    logic [31:0] frame_dst;
    logic        tbl_valid [TABLE_DEPTH];
    logic [31:0] tbl_key   [TABLE_DEPTH];
    logic [47:0] tbl_smac  [TABLE_DEPTH];
    logic [47:0] tbl_dmac  [TABLE_DEPTH];
    logic [7:0]  tbl_iface [TABLE_DEPTH];

    verdict_t    verdicts_due[$];
    logic [31:0] key_pool[KEY_POOL_SIZE];
    int          fail_count = 0;
    int          requests_sent = 0;
    bit          steady = 1'b0;

    ipv4_mac_rewrite_forwarder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .command         (command),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .entry_index     (entry_index),
        .entry_valid     (entry_valid),
        .key_address     (key_address),
        .new_source_mac  (new_source_mac),
        .new_dest_mac    (new_dest_mac),
        .entry_interface (entry_interface),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .verdict         (verdict),
        .out_interface   (out_interface),
        .source_mac      (source_mac),
        .dest_mac        (dest_mac)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver back-pressure, off during the steady stretch
    always @(negedge clk)
    begin
        result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic logic [47:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // Predict the effect of the request accepted this cycle
    task automatic predict_request();
        verdict_t v;
        int       need;
        bit       hit;
        if (command == CMD_TABLE_WRITE)
        begin
            if (int'(entry_index) < TABLE_DEPTH)
            begin
                tbl_valid[entry_index] = entry_valid;
                tbl_key[entry_index]   = key_address;
                tbl_smac[entry_index]  = new_source_mac;
                tbl_dmac[entry_index]  = new_dest_mac;
                tbl_iface[entry_index] = entry_interface;
            end
            return;
        end
        // Capture header fields by byte position
        if (frame_len == POS_TYPE_HI || frame_len == POS_TYPE_LO)
            frame_type = {frame_type[7:0], data_byte};
        else if (frame_len == POS_IHL)
            frame_ihl = data_byte[3:0];
        else if (frame_len >= POS_DST_HEAD && frame_len <= POS_DST_TAIL)
            frame_dst = {frame_dst[23:0], data_byte};
        if (frame_len != COUNT_MAX)
            frame_len = frame_len + 7'd1;
        if (!last_byte)
            return;
        v.verdict = VERDICT_PASS;
        v.iface   = '0;
        v.smac    = '0;
        v.dmac    = '0;
        need = int'(ETH_HEADER_LEN) + IHL_UNIT_BYTES * int'(frame_ihl);
        hit = 1'b0;
        if (frame_len < ETH_HEADER_LEN)
            v.verdict = VERDICT_DROP;
        else if (frame_type != ETHERTYPE_IPV4)
            v.verdict = VERDICT_PASS;
        else if (frame_len < IPV4_MIN_LEN || int'(frame_len) < need)
            v.verdict = VERDICT_DROP;
        else
        begin
            // Lowest matching slot wins
            for (int i = 0; i < TABLE_DEPTH && !hit; i++)
            begin
                if (tbl_valid[i] && tbl_key[i] == frame_dst)
                begin
                    hit       = 1'b1;
                    v.verdict = VERDICT_REDIRECT;
                    v.iface   = tbl_iface[i];
                    v.smac    = tbl_smac[i];
                    v.dmac    = tbl_dmac[i];
                end
            end
        end
        verdicts_due.push_back(v);
        frame_len  = '0;
        frame_type = '0;
        frame_ihl  = '0;
        frame_dst  = '0;
    endtask

    // Request monitor
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            predict_request();
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        verdict_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict %0d", $time, verdict);
                fail_count++;
            end
            else
            begin
                due = verdicts_due.pop_front();
                if (verdict !== due.verdict)
                begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, due.verdict, verdict);
                    fail_count++;
                end
                if (out_interface !== due.iface)
                begin
                    $display("%0t: out_interface expected %0d actual %0d",
                             $time, due.iface, out_interface);
                    fail_count++;
                end
                if (source_mac !== due.smac)
                begin
                    $display("%0t: source_mac expected %h actual %h",
                             $time, due.smac, source_mac);
                    fail_count++;
                end
                if (dest_mac !== due.dmac)
                begin
                    $display("%0t: dest_mac expected %h actual %h",
                             $time, due.dmac, dest_mac);
                    fail_count++;
                end
            end
        end
    end

    // Send one request; called at a falling edge, returns at a falling edge
    task automatic send_request(input request_t r);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        command         <= r.command;
        data_byte       <= r.data_byte;
        last_byte       <= r.last_byte;
        entry_index     <= r.entry_index;
        entry_valid     <= r.entry_valid;
        key_address     <= r.key_address;
        new_source_mac  <= r.new_source_mac;
        new_dest_mac    <= r.new_dest_mac;
        entry_interface <= r.entry_interface;
        req_valid       <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // Frame byte; the table fields carry noise
    task automatic send_byte(input logic [7:0] b, input logic last);
        request_t r;
        r.command         = CMD_FRAME_BYTE;
        r.data_byte       = b;
        r.last_byte       = last;
        r.entry_index     = 4'($urandom_range(0, 15));
        r.entry_valid     = 1'($urandom_range(0, 1));
        r.key_address     = $urandom;
        r.new_source_mac  = random_mac();
        r.new_dest_mac    = random_mac();
        r.entry_interface = 8'($urandom_range(0, 255));
        send_request(r);
    endtask

    // Table write; the frame fields carry noise
    task automatic send_table_write(input logic [3:0] idx, input logic vld,
                                    input logic [31:0] key, input logic [47:0] smac,
                                    input logic [47:0] dmac, input logic [7:0] iface);
        request_t r;
        r.command         = CMD_TABLE_WRITE;
        r.data_byte       = 8'($urandom_range(0, 255));
        r.last_byte       = 1'($urandom_range(0, 1));
        r.entry_index     = idx;
        r.entry_valid     = vld;
        r.key_address     = key;
        r.new_source_mac  = smac;
        r.new_dest_mac    = dmac;
        r.entry_interface = iface;
        send_request(r);
    endtask

    task automatic send_random_write();
        logic [31:0] key;
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                          : $urandom;
        send_table_write(4'($urandom_range(0, 15)), $urandom_range(0, 99) < 80, key,
                         random_mac(), random_mac(), 8'($urandom_range(0, 255)));
    endtask

    // Byte at a given position of a frame with the given header fields
    function automatic logic [7:0] frame_byte(input int pos, input logic [15:0] etype,
                                              input logic [3:0] ihl, input logic [31:0] dst);
        if (pos == int'(POS_TYPE_HI))
            return etype[15:8];
        if (pos == int'(POS_TYPE_LO))
            return etype[7:0];
        if (pos == int'(POS_IHL))
            return {4'($urandom_range(0, 15)), ihl};
        if (pos >= int'(POS_DST_HEAD) && pos <= int'(POS_DST_TAIL))
            return dst[8 * (int'(POS_DST_TAIL) - pos) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    // Whole frame, with table writes slipped in between bytes at mid_pct percent
    task automatic send_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [31:0] dst, input int mid_pct);
        for (int p = 0; p < len; p++)
        begin
            if (p > 0 && $urandom_range(0, 99) < mid_pct)
                send_random_write();
            send_byte(frame_byte(p, etype, ihl, dst), p == len - 1);
        end
    endtask

    // Length and EtherType rules with an empty table
    task automatic test_header_rules();
        send_frame(1, ETHERTYPE_IPV4, 4'd5, 32'hC0A8_0001, 0);
        send_frame(13, ETHERTYPE_IPV4, 4'd5, 32'hC0A8_0001, 0);
        send_frame(14, ETHERTYPE_IPV4, 4'd5, 32'hC0A8_0001, 0);
        send_frame(14, 16'h86DD, 4'd5, 32'hC0A8_0001, 0);
        send_frame(33, ETHERTYPE_IPV4, 4'd5, 32'hC0A8_0001, 0);
        send_frame(34, ETHERTYPE_IPV4, 4'd5, 32'hC0A8_0001, 0);
        // IHL below five only meets the length checks
        send_frame(34, ETHERTYPE_IPV4, 4'd0, 32'hC0A8_0002, 0);
        send_frame(73, ETHERTYPE_IPV4, 4'd15, 32'hC0A8_0003, 0);
        send_frame(74, ETHERTYPE_IPV4, 4'd15, 32'hC0A8_0003, 0);
    endtask

    // Hits, slot priority and removal
    task automatic test_table_hits();
        send_table_write(4'd15, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                         8'hFF);
        send_frame(34, ETHERTYPE_IPV4, 4'd5, 32'hFFFF_FFFF, 0);
        send_table_write(4'd0, 1'b1, 32'h0, 48'h0, 48'h0, 8'h00);
        send_frame(40, ETHERTYPE_IPV4, 4'd6, 32'h0, 0);
        // Same key in two slots: lower index must win
        send_table_write(4'd9, 1'b1, 32'h0A00_0001, 48'h0200_0000_0009, 48'h0400_0000_0009,
                         8'd9);
        send_table_write(4'd3, 1'b1, 32'h0A00_0001, 48'h0200_0000_0003, 48'h0400_0000_0003,
                         8'd3);
        send_frame(34, ETHERTYPE_IPV4, 4'd5, 32'h0A00_0001, 0);
        send_table_write(4'd3, 1'b0, 32'h0A00_0001, random_mac(), random_mac(), 8'd77);
        send_frame(34, ETHERTYPE_IPV4, 4'd5, 32'h0A00_0001, 0);
        send_table_write(4'd9, 1'b0, 32'h0A00_0001, random_mac(), random_mac(), 8'd78);
        send_frame(34, ETHERTYPE_IPV4, 4'd5, 32'h0A00_0001, 0);
        // Non-IPv4 frames never look up
        send_frame(60, 16'h0806, 4'd5, 32'h0, 0);
    endtask

    // Table writes landing inside a frame act at once
    task automatic test_mid_frame_write();
        for (int p = 0; p < 40; p++)
        begin
            if (p == 20)
                send_table_write(4'd7, 1'b1, 32'hAC10_0505, 48'h0A0B_0C0D_0E0F,
                                 48'h1112_1314_1516, 8'd42);
            send_byte(frame_byte(p, ETHERTYPE_IPV4, 4'd5, 32'hAC10_0505), p == 39);
        end
        for (int p = 0; p < 40; p++)
        begin
            if (p == 36)
                send_table_write(4'd7, 1'b0, 32'hAC10_0505, random_mac(), random_mac(), 8'd1);
            send_byte(frame_byte(p, ETHERTYPE_IPV4, 4'd5, 32'hAC10_0505), p == 39);
        end
    endtask

    // Byte count saturation
    task automatic test_long_frame();
        send_frame(127, ETHERTYPE_IPV4, 4'd15, 32'hFFFF_FFFF, 0);
        send_frame(128, ETHERTYPE_IPV4, 4'd15, 32'hFFFF_FFFF, 0);
        send_frame(200, ETHERTYPE_IPV4, 4'd15, 32'h0, 0);
    endtask

    // Mostly well-formed IPv4 frames against a busy table, plus noise
    task automatic test_random();
        int          start;
        int          kind;
        int          len;
        int          max_ihl;
        logic [3:0]  ihl;
        logic [31:0] dst;
        start = requests_sent;
        for (int k = 2; k < KEY_POOL_SIZE; k++)
            key_pool[k] = $urandom;
        while (requests_sent < start + RANDOM_ITEMS)
        begin
            // One long stretch with no idling on either side
            steady = (requests_sent - start > RANDOM_ITEMS / 3) &&
                     (requests_sent - start < RANDOM_ITEMS / 2);
            kind = $urandom_range(0, 99);
            dst = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                               : $urandom;
            if (kind < 12)
                send_random_write();
            else if (kind < 72)
            begin
                len = $urandom_range(34, 80);
                max_ihl = (len - int'(ETH_HEADER_LEN)) / IHL_UNIT_BYTES;
                if (max_ihl > 15)
                    max_ihl = 15;
                ihl = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, max_ihl))
                                                   : 4'($urandom_range(0, 15));
                send_frame(len, ETHERTYPE_IPV4, ihl, dst, 5);
            end
            else if (kind < 82)
                send_frame($urandom_range(14, 70), 16'($urandom_range(0, 65535)),
                           4'($urandom_range(0, 15)), dst, 5);
            else if (kind < 94)
                send_frame($urandom_range(1, 36), ETHERTYPE_IPV4, 4'($urandom_range(0, 15)),
                           dst, 5);
            else if (kind < 97)
                send_frame($urandom_range(100, 200), ETHERTYPE_IPV4,
                           4'($urandom_range(5, 15)), dst, 2);
            else
                send_frame($urandom_range(1, 80), 16'($urandom_range(0, 65535)),
                           4'($urandom_range(0, 15)), $urandom, 10);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        command         = CMD_FRAME_BYTE;
        data_byte       = '0;
        last_byte       = 1'b0;
        entry_index     = '0;
        entry_valid     = 1'b0;
        key_address     = '0;
        new_source_mac  = '0;
        new_dest_mac    = '0;
        entry_interface = '0;
        result_stall    = 1'b0;
        frame_len       = '0;
        frame_type      = '0;
        frame_ihl       = '0;
        frame_dst       = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_smac[i]  = '0;
            tbl_dmac[i]  = '0;
            tbl_iface[i] = '0;
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < KEY_POOL_SIZE; k++)
            key_pool[k] = $urandom;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_header_rules();
        test_table_hits();
        test_mid_frame_write();
        test_long_frame();
        test_random();

        req_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (fail_count == 0)
            $display("ipv4_mac_rewrite_forwarder_tb OK");
        else
            $display("ipv4_mac_rewrite_forwarder_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("%0t: timeout with %0d verdicts outstanding", $time, verdicts_due.size());
        $display("ipv4_mac_rewrite_forwarder_tb NOT OK");
        $finish;
    end

endmodule
